// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold at every clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/prq_pkg.sv =====
`timescale 1ns / 1ps
package prq_pkg;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_ACK     = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_POOL_FULL = 3'd1,
        ST_NO_ENTRY  = 3'd2,
        ST_FIFO_FULL = 3'd3,
        ST_NONE_DUE  = 3'd4,
        ST_IGNORED   = 3'd5,
        ST_MISMATCH  = 3'd6,
        ST_NOT_FOUND = 3'd7
    } status_t;

    localparam logic [1:0] REG_RETRY_LIMIT   = 2'd0;
    localparam logic [1:0] REG_FIRST_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_EXTRA_TIMEOUT = 2'd2;

endpackage

// ===== hdl/per_receiver_retry_queue_core.sv =====
`timescale 1ns / 1ps
// Per-receiver retry queue. The block holds a pool of request slots and, for
// each receiver entry, a FIFO of slot numbers. Each accepted beat on the input
// channel is one command (enqueue, tick or acknowledgement) and yields exactly
// one result beat. The block works on one command at a time: a small
// sequencer walks the slot pool and the receiver entries one element per
// cycle. The scan walks, the FIFO shift on a pop and the single shared
// multiply-add for the retry timeout set how long a command takes; an ignored
// or unknown command skips the walks. While a command is being worked
// on, in_stall stays high. The result sits in an output register and waits
// there for the receiver; in_stall also stays high while that result beat
// waits, so the next command is accepted only once the previous result beat
// has been taken. Configuration is written through a plain write port and
// must only be written while the block is idle. There is no clearing pass
// after reset: slot and entry valid bits are flip-flops cleared by reset.
module per_receiver_retry_queue_core
    import prq_pkg::*;
#(
    parameter int POOL_SLOTS       = 16,
    parameter int RECEIVER_ENTRIES = 8,
    parameter int FIFO_DEPTH       = 4,
    parameter int MAX_PAYLOAD      = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // Command channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] target_id,
    input  logic [7:0]  request_type,
    input  logic [7:0]  key_index,
    input  logic [7:0]  payload_length,
    input  logic [31:0] counter_value,
    input  logic [15:0] ack_origin,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [3:0]  slot_index,
    output logic [15:0] dest_id,
    output logic [7:0]  send_type,
    output logic [7:0]  send_key,
    output logic [5:0]  send_length,
    output logic [7:0]  try_number,
    output logic        final_try,
    output logic        queue_emptied
);

    localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int EW = (RECEIVER_ENTRIES > 1) ? $clog2(RECEIVER_ENTRIES) : 1;
    localparam int FW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int NW = $clog2(FIFO_DEPTH + 1);
    localparam int LW = 8;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_SLOT,
        S_ENQ_MATCH,
        S_ENQ_FREE,
        S_ENQ_COMMIT,
        S_TICK_SCAN,
        S_TICK_MUL,
        S_TICK_POP,
        S_ACK_SCAN,
        S_ACK_POP,
        S_DONE
    } state_t;

    // Configuration registers.
    logic [7:0] retry_limit_reg, first_timeout_reg, extra_timeout_reg;

    // Slot pool.
    logic [POOL_SLOTS-1:0] slot_busy_reg;
    logic [7:0]  slot_type_mem    [POOL_SLOTS];
    logic [7:0]  slot_key_mem     [POOL_SLOTS];
    logic [5:0]  slot_length_mem  [POOL_SLOTS];
    logic [31:0] slot_counter_mem [POOL_SLOTS];
    logic [7:0]  slot_wait_mem    [POOL_SLOTS];
    logic [7:0]  slot_tries_mem   [POOL_SLOTS];

    // Receiver entries and their FIFOs (head always at position 0).
    logic [RECEIVER_ENTRIES-1:0] entry_valid_reg;
    logic [15:0]   entry_device_mem [RECEIVER_ENTRIES];
    logic [SW-1:0] fifo_mem [RECEIVER_ENTRIES][FIFO_DEPTH];
    logic [NW-1:0] fifo_fill_reg [RECEIVER_ENTRIES];

    // Sequencer.
    state_t state_reg;
    logic [SW:0]   scan_reg;
    logic [EW:0]   ent_reg;
    logic [FW:0]   pop_reg;
    logic [SW-1:0] slot_reg;
    logic [EW-1:0] hit_reg;
    logic          found_reg;

    // Captured command.
    logic [15:0] dev_reg;
    logic [7:0]  type_reg, key_reg, len_reg;
    logic [31:0] ctr_reg;
    logic [15:0] prod_reg;

    // Result register.
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [3:0]  slot_out_reg;
    logic [15:0] dest_reg;
    logic [7:0]  stype_reg, skey_reg, tries_out_reg;
    logic [5:0]  slen_reg;
    logic        fin_reg, empt_reg;

    // Current entry and slot under the scan pointer.
    logic [EW-1:0] e_cur;
    logic [SW-1:0] s_head;
    logic [SW-1:0] s_cur;
    logic [7:0]    wait_dec;
    logic [7:0]    tries_inc;
    logic [16:0]   wait_sum;

    assign e_cur     = ent_reg[EW-1:0];
    assign s_cur     = scan_reg[SW-1:0];
    assign s_head    = fifo_mem[e_cur][0];
    assign wait_dec  = (slot_wait_mem[s_head] != 8'd0) ?
                       slot_wait_mem[s_head] - 8'd1 : 8'd0;
    assign tries_inc = (slot_tries_mem[s_head] != 8'hFF) ?
                       slot_tries_mem[s_head] + 8'd1 : 8'hFF;
    assign wait_sum  = {1'b0, prod_reg} + 17'(first_timeout_reg);

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status        = status_reg;
    assign slot_index    = slot_out_reg;
    assign dest_id       = dest_reg;
    assign send_type     = stype_reg;
    assign send_key      = skey_reg;
    assign send_length   = slen_reg;
    assign try_number    = tries_out_reg;
    assign final_try     = fin_reg;
    assign queue_emptied = empt_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg   <= 8'd2;
            first_timeout_reg <= 8'd2;
            extra_timeout_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data;
                REG_FIRST_TIMEOUT: first_timeout_reg <= cfg_data;
                REG_EXTRA_TIMEOUT: extra_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Payload stores: no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_ENQ_COMMIT:
            begin
                if (!entry_valid_reg[hit_reg])
                    entry_device_mem[hit_reg] <= dev_reg;
                fifo_mem[hit_reg][FW'(entry_valid_reg[hit_reg] ?
                    fifo_fill_reg[hit_reg] : NW'(0))] <= slot_reg;
                slot_type_mem[slot_reg]    <= type_reg;
                slot_key_mem[slot_reg]     <= key_reg;
                slot_length_mem[slot_reg]  <= (len_reg > MAX_LEN) ?
                                              MAX_LEN[5:0] : len_reg[5:0];
                slot_counter_mem[slot_reg] <= 32'd0;
                slot_wait_mem[slot_reg]    <= 8'd1;
                slot_tries_mem[slot_reg]   <= 8'd0;
            end
            S_TICK_SCAN:
            begin
                if (ent_reg < (EW+1)'(RECEIVER_ENTRIES) && entry_valid_reg[e_cur]
                    && fifo_fill_reg[e_cur] != NW'(0))
                begin
                    if (wait_dec == 8'd0 && !found_reg)
                    begin
                        slot_wait_mem[s_head]    <= 8'd0;
                        slot_counter_mem[s_head] <= ctr_reg;
                        slot_tries_mem[s_head]   <= tries_inc;
                    end
                    else
                        slot_wait_mem[s_head] <= wait_dec;
                end
            end
            S_TICK_MUL:
                slot_wait_mem[slot_reg] <= (wait_sum > 17'd255) ? 8'hFF :
                                           wait_sum[7:0];
            S_TICK_POP, S_ACK_POP:
                if (pop_reg < (FW+1)'(FIFO_DEPTH - 1))
                    fifo_mem[hit_reg][pop_reg[FW-1:0]] <=
                        fifo_mem[hit_reg][FW'(pop_reg + (FW+1)'(1))];
            default: ;
        endcase
    end

    // Sequencer, control state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slot_busy_reg   <= '0;
            entry_valid_reg <= '0;
            for (int i = 0; i < RECEIVER_ENTRIES; i++)
                fifo_fill_reg[i] <= '0;
            out_valid_reg   <= 1'b0;
            scan_reg  <= '0;
            ent_reg   <= '0;
            pop_reg   <= '0;
            slot_reg  <= '0;
            hit_reg   <= '0;
            found_reg <= 1'b0;
            dev_reg   <= '0;
            type_reg  <= '0;
            key_reg   <= '0;
            len_reg   <= '0;
            ctr_reg   <= '0;
            prod_reg  <= '0;
            status_reg <= '0;
            slot_out_reg <= '0;
            dest_reg  <= '0;
            stype_reg <= '0;
            skey_reg  <= '0;
            slen_reg  <= '0;
            tries_out_reg <= '0;
            fin_reg   <= 1'b0;
            empt_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !out_valid_reg)
                    begin
                        dev_reg    <= target_id;
                        type_reg   <= request_type;
                        key_reg    <= key_index;
                        len_reg    <= payload_length;
                        ctr_reg    <= counter_value;
                        scan_reg   <= '0;
                        ent_reg    <= '0;
                        found_reg  <= 1'b0;
                        status_reg <= ST_OK;
                        slot_out_reg <= '0;
                        dest_reg  <= '0;
                        stype_reg <= '0;
                        skey_reg  <= '0;
                        slen_reg  <= '0;
                        tries_out_reg <= '0;
                        fin_reg   <= 1'b0;
                        empt_reg  <= 1'b0;
                        case (cmd_t'(cmd))
                            CMD_ENQUEUE: state_reg <= S_ENQ_SLOT;
                            CMD_TICK:    state_reg <= S_TICK_SCAN;
                            CMD_ACK:
                            begin
                                if (ack_origin != 16'd0)
                                begin
                                    status_reg <= ST_IGNORED;
                                    state_reg  <= S_DONE;
                                end
                                else
                                    state_reg <= S_ACK_SCAN;
                            end
                            default:
                            begin
                                status_reg <= ST_IGNORED;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ENQ_SLOT:
                begin
                    if (scan_reg == (SW+1)'(POOL_SLOTS))
                    begin
                        status_reg <= ST_POOL_FULL;
                        state_reg  <= S_DONE;
                    end
                    else if (!slot_busy_reg[s_cur])
                    begin
                        slot_reg  <= s_cur;
                        state_reg <= S_ENQ_MATCH;
                    end
                    else
                        scan_reg <= scan_reg + (SW+1)'(1);
                end
                S_ENQ_MATCH:
                begin
                    if (ent_reg == (EW+1)'(RECEIVER_ENTRIES))
                    begin
                        ent_reg   <= '0;
                        state_reg <= S_ENQ_FREE;
                    end
                    else if (entry_valid_reg[e_cur] &&
                             entry_device_mem[e_cur] == dev_reg)
                    begin
                        hit_reg <= e_cur;
                        if (fifo_fill_reg[e_cur] >= NW'(FIFO_DEPTH))
                        begin
                            status_reg <= ST_FIFO_FULL;
                            state_reg  <= S_DONE;
                        end
                        else
                            state_reg <= S_ENQ_COMMIT;
                    end
                    else
                        ent_reg <= ent_reg + (EW+1)'(1);
                end
                S_ENQ_FREE:
                begin
                    if (ent_reg == (EW+1)'(RECEIVER_ENTRIES))
                    begin
                        status_reg <= ST_NO_ENTRY;
                        state_reg  <= S_DONE;
                    end
                    else if (!entry_valid_reg[e_cur])
                    begin
                        hit_reg   <= e_cur;
                        state_reg <= S_ENQ_COMMIT;
                    end
                    else
                        ent_reg <= ent_reg + (EW+1)'(1);
                end
                S_ENQ_COMMIT:
                begin
                    entry_valid_reg[hit_reg] <= 1'b1;
                    fifo_fill_reg[hit_reg] <= (entry_valid_reg[hit_reg] ?
                        fifo_fill_reg[hit_reg] : NW'(0)) + NW'(1);
                    slot_busy_reg[slot_reg] <= 1'b1;
                    slot_out_reg <= 4'(slot_reg);
                    state_reg    <= S_DONE;
                end
                S_TICK_SCAN:
                begin
                    if (ent_reg == (EW+1)'(RECEIVER_ENTRIES))
                    begin
                        if (!found_reg)
                            status_reg <= ST_NONE_DUE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ent_reg <= ent_reg + (EW+1)'(1);
                        if (entry_valid_reg[e_cur] &&
                            fifo_fill_reg[e_cur] != NW'(0) &&
                            wait_dec == 8'd0 && !found_reg)
                        begin
                            found_reg     <= 1'b1;
                            slot_reg      <= s_head;
                            hit_reg       <= e_cur;
                            slot_out_reg  <= 4'(s_head);
                            dest_reg      <= entry_device_mem[e_cur];
                            stype_reg     <= slot_type_mem[s_head];
                            skey_reg      <= slot_key_mem[s_head];
                            slen_reg      <= slot_length_mem[s_head];
                            tries_out_reg <= tries_inc;
                            if (tries_inc > retry_limit_reg)
                            begin
                                slot_busy_reg[s_head] <= 1'b0;
                                fin_reg   <= 1'b1;
                                pop_reg   <= '0;
                                state_reg <= S_TICK_POP;
                            end
                            else
                            begin
                                prod_reg  <= 16'(tries_inc - 8'd1) *
                                             16'(extra_timeout_reg);
                                state_reg <= S_TICK_MUL;
                            end
                        end
                    end
                end
                S_TICK_MUL:
                    state_reg <= S_TICK_SCAN;
                S_TICK_POP, S_ACK_POP:
                begin
                    if (pop_reg >= (FW+1)'(FIFO_DEPTH - 1))
                    begin
                        if (fifo_fill_reg[hit_reg] <= NW'(1))
                        begin
                            fifo_fill_reg[hit_reg]   <= '0;
                            entry_valid_reg[hit_reg] <= 1'b0;
                            empt_reg <= 1'b1;
                        end
                        else
                            fifo_fill_reg[hit_reg] <= fifo_fill_reg[hit_reg] - NW'(1);
                        state_reg <= (state_reg == S_TICK_POP) ? S_TICK_SCAN : S_DONE;
                    end
                    else
                        pop_reg <= pop_reg + (FW+1)'(1);
                end
                S_ACK_SCAN:
                begin
                    if (ent_reg == (EW+1)'(RECEIVER_ENTRIES))
                    begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_DONE;
                    end
                    else if (entry_valid_reg[e_cur] &&
                             entry_device_mem[e_cur] == dev_reg)
                    begin
                        if (fifo_fill_reg[e_cur] == NW'(0) ||
                            slot_counter_mem[s_head] != ctr_reg)
                        begin
                            status_reg <= ST_MISMATCH;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            slot_busy_reg[s_head] <= 1'b0;
                            slot_out_reg <= 4'(s_head);
                            hit_reg   <= e_cur;
                            pop_reg   <= '0;
                            state_reg <= S_ACK_POP;
                        end
                    end
                    else
                        ent_reg <= ent_reg + (EW+1)'(1);
                end
                S_DONE:
                begin
                    // The output register is always empty here, since a
                    // command is only taken once the previous beat has left.
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/prq_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prq_checker
    import prq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [7:0]  try_number,
    input logic        final_try,
    input logic        queue_emptied
);

    // After a command is accepted, in_stall is high in the next cycle.
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "not busy after accept")
    // A waiting result holds its status.
    `ASSERT_CLK(a_hold_status, clk, rst_n, (out_valid && out_stall) |=> $stable(status), "status changed while stalled")
    // A dropped request was sent at least once.
    `ASSERT_CLK(a_final_tries, clk, rst_n, (out_valid && final_try) |-> (try_number != 8'd0), "drop with zero tries")
    // Error results carry no released entry.
    `ASSERT_CLK(a_err_clean, clk, rst_n, (out_valid && status != ST_OK) |-> !queue_emptied, "error with emptied flag")

endmodule

bind per_receiver_retry_queue_core prq_checker u_prq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .try_number(try_number), .final_try(final_try), .queue_emptied(queue_emptied)
);
